FILE: sv/dsbam_pkg.sv
`default_nettype none
package dsbam_pkg;

  localparam int SIDE_TRACKS = 35;
  localparam int NUM_TRACKS  = 2 * SIDE_TRACKS;
  localparam int DIR_TRACK   = 18;
  localparam int IDX_W       = $clog2(NUM_TRACKS);
  localparam int MAP_W       = 21;
  localparam int CNT_W       = 5;
  localparam int TOT_W       = 12;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_LOAD  = 2'd2;
  localparam logic [1:0] KIND_RSVD  = 2'd3;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_ILLEGAL = 2'd1;
  localparam logic [1:0] STAT_SAME    = 2'd2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [1:0]       kind;
    logic [6:0]       track;
    logic [4:0]       sector;
    logic [MAP_W-1:0] load_bitmap;
    logic [CNT_W-1:0] load_count;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] track_free;
    logic [TOT_W-1:0] blocks_free;
  } rsp_t;

  typedef struct packed {
    logic [MAP_W-1:0] bitmap;
    logic [CNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic             wr_en;
    entry_t           entry;
    logic [1:0]       status;
    logic [CNT_W-1:0] track_free;
    logic [TOT_W-1:0] total;
  } upd_t;

  function automatic logic [4:0] zone_sectors(input logic [6:0] track);
    logic [6:0] rel;
    rel = (track > 7'(SIDE_TRACKS)) ? track - 7'(SIDE_TRACKS) : track;
    if (rel < 7'd18) return 5'd21;
    if (rel < 7'd25) return 5'd19;
    if (rel < 7'd31) return 5'd18;
    return 5'd17;
  endfunction

  function automatic logic is_dir_track(input logic [6:0] track);
    return (track == 7'(DIR_TRACK)) || (track == 7'(SIDE_TRACKS + DIR_TRACK));
  endfunction

  function automatic entry_t entry_reset(input logic [6:0] track);
    entry_t     e;
    logic [4:0] n;
    n = zone_sectors(track);
    e.bitmap = ~({MAP_W{1'b1}} << n);
    e.count  = n;
    if (is_dir_track(track)) begin
      e.bitmap[0] = 1'b0;
      e.count     = n - 5'd1;
    end
    return e;
  endfunction

  function automatic logic [TOT_W-1:0] total_reset();
    logic [TOT_W-1:0] s;
    s = '0;
    for (int t = 1; t <= NUM_TRACKS; t++) begin
      if (!is_dir_track(7'(t))) s = s + TOT_W'(zone_sectors(7'(t)));
    end
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: sv/dual_side_block_allocation_map_top.sv
`default_nettype none
// Block availability map for a two-sided disk: per track a free-sector bitmap and free
// count, plus a running free total that leaves out the two directory tracks. For each
// request the track's entry is first read from the track table into a register; in the
// next cycle it is updated, written back and placed in the result register. A new
// request is not taken while one is in flight, and is held off while a result waits
// under stall. There is no clearing pass after reset: per-track valid bits make untouched
// tracks read as their reset map.
module dual_side_block_allocation_map_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_stall,
  input  wire dsbam_pkg::req_t req,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  output dsbam_pkg::rsp_t rsp
);

  localparam logic [dsbam_pkg::TOT_W-1:0] TOTAL_INIT = dsbam_pkg::total_reset();

  logic                          busy;
  logic                          accept;
  dsbam_pkg::req_t               req_q;
  logic [dsbam_pkg::TOT_W-1:0]   total;
  dsbam_pkg::entry_t             rd_data;
  dsbam_pkg::upd_t               upd;
  logic [dsbam_pkg::IDX_W-1:0]   rd_addr;
  logic [dsbam_pkg::IDX_W-1:0]   wr_addr;

  assign req_stall = busy || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;
  assign rd_addr   = dsbam_pkg::IDX_W'(req.track - 7'd1);
  assign wr_addr   = dsbam_pkg::IDX_W'(req_q.track - 7'd1);

  dsbam_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (busy && upd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (upd.entry)
  );

  dsbam_update u_update (
    .req   (req_q),
    .entry (rd_data),
    .total (total),
    .upd   (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rsp_valid <= 1'b0;
      total     <= TOTAL_INIT;
    end else begin
      busy <= accept;
      if (busy) begin
        rsp_valid <= 1'b1;
        total     <= upd.total;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (busy) begin
      rsp.status      <= upd.status;
      rsp.track_free  <= upd.track_free;
      rsp.blocks_free <= upd.total;
    end
  end

endmodule
`default_nettype wire

FILE: sv/dsbam_store.sv
`default_nettype none
module dsbam_store (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      rd_en,
  input  wire logic [dsbam_pkg::IDX_W-1:0] rd_addr,
  output dsbam_pkg::entry_t              rd_data,
  input  wire logic                      wr_en,
  input  wire logic [dsbam_pkg::IDX_W-1:0] wr_addr,
  input  wire dsbam_pkg::entry_t         wr_data
);

  dsbam_pkg::entry_t mem [dsbam_pkg::NUM_TRACKS];
  logic [dsbam_pkg::NUM_TRACKS-1:0] valid;

  dsbam_pkg::entry_t            mem_q;
  logic                         valid_q;
  logic [dsbam_pkg::IDX_W-1:0]  addr_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q  <= mem[rd_addr];
      addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        valid_q <= (rd_addr < dsbam_pkg::IDX_W'(dsbam_pkg::NUM_TRACKS)) && valid[rd_addr];
      end
    end
  end

  // untouched entries read as their reset contents
  assign rd_data = valid_q ? mem_q : dsbam_pkg::entry_reset(7'(addr_q) + 7'd1);

endmodule
`default_nettype wire

FILE: sv/dsbam_update.sv
`default_nettype none
module dsbam_update (
  input  wire dsbam_pkg::req_t             req,
  input  wire dsbam_pkg::entry_t           entry,
  input  wire logic [dsbam_pkg::TOT_W-1:0] total,
  output dsbam_pkg::upd_t                  upd
);

  logic                            illegal;
  logic [dsbam_pkg::MAP_W-1:0]     mask;
  logic                            is_free;
  dsbam_pkg::entry_t               nxt;
  logic [1:0]                      status;

  always_comb begin
    illegal = (req.kind == dsbam_pkg::KIND_RSVD) || (req.track == 7'd0) ||
              (req.track > 7'(dsbam_pkg::NUM_TRACKS)) ||
              ((req.kind != dsbam_pkg::KIND_LOAD) &&
               (req.sector >= dsbam_pkg::zone_sectors(req.track)));
    mask    = dsbam_pkg::MAP_W'(1) << req.sector;
    is_free = |(entry.bitmap & mask);
    nxt     = entry;
    status  = dsbam_pkg::STAT_DONE;
    case (req.kind)
      dsbam_pkg::KIND_ALLOC: begin
        if (!is_free) begin
          status = dsbam_pkg::STAT_SAME;
        end else begin
          nxt.bitmap = entry.bitmap & ~mask;
          if (entry.count != '0) nxt.count = entry.count - 5'd1;
        end
      end
      dsbam_pkg::KIND_FREE: begin
        if (is_free) begin
          status = dsbam_pkg::STAT_SAME;
        end else begin
          nxt.bitmap = entry.bitmap | mask;
          if (entry.count != dsbam_pkg::CNT_MAX) nxt.count = entry.count + 5'd1;
        end
      end
      default: begin
        nxt.bitmap = req.load_bitmap;
        nxt.count  = req.load_count;
      end
    endcase

    upd.entry = nxt;
    if (illegal) begin
      upd.wr_en      = 1'b0;
      upd.status     = dsbam_pkg::STAT_ILLEGAL;
      upd.track_free = '0;
      upd.total      = total;
    end else begin
      upd.wr_en      = 1'b1;
      upd.status     = status;
      upd.track_free = nxt.count;
      upd.total      = dsbam_pkg::is_dir_track(req.track) ? total :
                       total - dsbam_pkg::TOT_W'(entry.count) + dsbam_pkg::TOT_W'(nxt.count);
    end
  end

endmodule
`default_nettype wire
